@@ hw/rtl/dq_pkg.sv @@
// Shared types and constants for the double-ended queue.
// No dependencies; compile this file first.
package dq_pkg;

  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic shift_right;  // push at front: every cell takes its left neighbor
    logic shift_left;   // pop at front: every cell takes its right neighbor
    logic push_back;    // first free cell captures the value
    logic pop_back;     // last occupied cell drops its entry
  } cell_ctrl_t;

endpackage

@@ hw/rtl/dq_cmd_if.sv @@
// Command channel of the double-ended queue: valid/ready plus command and value.
// Depends on dq_pkg.
interface dq_cmd_if;
  logic                      valid;
  logic                      ready;
  dq_pkg::cmd_t              command;
  logic signed [dq_pkg::DATA_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

@@ hw/rtl/dq_res_if.sv @@
// Result channel of the double-ended queue: valid/ready plus popped value,
// status and entry count. Depends on dq_pkg.
interface dq_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [dq_pkg::DATA_W-1:0]  popped_value;
  dq_pkg::status_t                   status;
  logic [dq_pkg::COUNT_W-1:0]        entry_count;

  modport source (output valid, output popped_value, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input popped_value, input status,
                  input entry_count, output ready);
endinterface

@@ hw/rtl/double_ended_queue_top.sv @@
// Top level of the double-ended queue: command decode, cell chain and result
// register. Depends on dq_pkg, dq_cmd_if, dq_res_if and dq_cell.
//
// The queue holds up to DEPTH signed 32-bit entries in a chain of cells, the
// front entry always in the first cell. Each command transaction yields one
// result transaction in the cycle after acceptance, and a new command is taken
// every cycle while the result register is empty or being drained, so the
// sustained rate is one command per cycle. Push at front shifts the whole
// chain one cell back and pop at front shifts it one cell forward; push and
// pop at back touch only the cell at the boundary of the occupied flags. The
// popped back entry is picked by an AND-OR select over all cells, which is the
// longest path and grows with DEPTH. Pushes on a full queue report ST_FULL and
// pops on an empty queue report ST_EMPTY, both leaving the queue unchanged.
// Entries need no clearing after reset; only the occupied flags are reset.
module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  dq_cmd_if.sink   cmd_in,
  dq_res_if.source res_out
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              accept;
  logic              full;
  logic              empty;
  cell_ctrl_t        ctrl;
  status_t           status_next;
  logic [DATA_W-1:0] popped_next;
  logic [DATA_W-1:0] tail_value;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_tail;

  logic              res_valid;
  logic [DATA_W-1:0] res_popped;
  status_t           res_status;
  logic [CW-1:0]     res_count;

  // Take a command whenever the result register is free or draining
  assign cmd_in.ready = ~res_valid | res_out.ready;
  assign accept       = cmd_in.valid & cmd_in.ready;
  assign full         = (count == CW'(DEPTH));
  assign empty        = (count == '0);

  // Gather the back entry from the cell that marks the tail
  always_comb begin
    tail_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_value = tail_value | (cell_data[i] & {DATA_W{cell_tail[i]}});
    end
  end

  // Decode the command into chain control, status and new count
  always_comb begin
    ctrl        = '0;
    status_next = ST_OK;
    popped_next = '0;
    count_next  = count;
    if (accept) begin
      unique case (cmd_in.command)
        CMD_PUSH_FRONT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            ctrl.shift_right = 1'b1;
            count_next       = count + 1'b1;
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            ctrl.push_back = 1'b1;
            count_next     = count + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            ctrl.shift_left = 1'b1;
            popped_next     = cell_data[0];
            count_next      = count - 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            ctrl.pop_back = 1'b1;
            popped_next   = tail_value;
            count_next    = count - 1'b1;
          end
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
  end

  // Build the chain; the ends see the pushed value and an empty neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic              left_valid;
    logic [DATA_W-1:0] right_data;
    logic              right_valid;

    if (i == 0) begin : g_first
      assign left_data  = cmd_in.value;
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    dq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .push_value  (cmd_in.value),
      .left_data   (left_data),
      .left_valid  (left_valid),
      .right_data  (right_data),
      .right_valid (right_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .tail        (cell_tail[i])
    );
  end

  // Hold the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_popped <= popped_next;
      res_status <= status_next;
      res_count  <= count_next;
    end
  end

  assign res_out.valid        = res_valid;
  assign res_out.popped_value = res_popped;
  assign res_out.status       = res_status;
  assign res_out.entry_count  = COUNT_W'(res_count);

  // Count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  // Occupied flags agree with the count
  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(count))
    else $error("cell flags disagree with entry count");

  // A pop on an empty queue reports empty and leaves the count at zero
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    accept && empty && (cmd_in.command == CMD_POP_FRONT ||
                        cmd_in.command == CMD_POP_BACK)
    |=> res_out.status == ST_EMPTY && count == '0 && res_out.popped_value == '0)
    else $error("pop on empty queue mishandled");

  // A push into a queue with room grows the count by one
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    accept && !full && (cmd_in.command == CMD_PUSH_FRONT ||
                        cmd_in.command == CMD_PUSH_BACK)
    |=> count == $past(count) + 1'b1 && res_out.status == ST_OK)
    else $error("push did not add an entry");

endmodule

@@ hw/rtl/dq_cell.sv @@
// One storage cell of the queue chain: an entry and its occupied flag.
// Trades data with its two neighbors; depends on dq_pkg.
module dq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  dq_pkg::cell_ctrl_t        ctrl,
  input  logic [dq_pkg::DATA_W-1:0] push_value,
  input  logic [dq_pkg::DATA_W-1:0] left_data,
  input  logic                      left_valid,
  input  logic [dq_pkg::DATA_W-1:0] right_data,
  input  logic                      right_valid,
  output logic [dq_pkg::DATA_W-1:0] data,
  output logic                      valid,
  output logic                      tail
);
  import dq_pkg::*;

  // This cell holds the back entry when its right neighbor is empty
  assign tail = valid & ~right_valid;

  // Occupied flag: shift with the chain, set on back push, clear on back pop
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift_right) begin
      valid <= left_valid;
    end else if (ctrl.shift_left) begin
      valid <= right_valid;
    end else if (ctrl.push_back && !valid && left_valid) begin
      valid <= 1'b1;
    end else if (ctrl.pop_back && tail) begin
      valid <= 1'b0;
    end
  end

  // Entry: follows the flag, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.shift_right) begin
      data <= left_data;
    end else if (ctrl.shift_left) begin
      data <= right_data;
    end else if (ctrl.push_back && !valid && left_valid) begin
      data <= push_value;
    end
  end

endmodule
